// ===== src/ptl_pkg.sv =====
package ptl_pkg;

   // Request kinds carried on req_type.
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_SET    = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   // Result status codes carried on rsp_status.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   // Command broadcast to every cell of the chain at once.
   typedef struct packed {
      logic ins;
      logic rem;
      logic set;
   } cell_op_type;

endpackage

// ===== src/ptl_cell.sv =====
module ptl_cell #(
   parameter int INDEX      = 0,
   parameter int IDX_W      = 4,
   parameter int NAME_BITS  = 64,
   parameter int STATE_BITS = 3
) (
   input  logic                    clock,
   input  ptl_pkg::cell_op_type    op,
   input  logic [IDX_W-1:0]        idx,
   input  logic [NAME_BITS-1:0]    new_name,
   input  logic [STATE_BITS-1:0]   new_state,
   input  logic [NAME_BITS-1:0]    prev_name,
   input  logic [STATE_BITS-1:0]   prev_state,
   input  logic [NAME_BITS-1:0]    next_name,
   input  logic [STATE_BITS-1:0]   next_state,
   output logic [NAME_BITS-1:0]    name_o,
   output logic [STATE_BITS-1:0]   state_o
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [NAME_BITS-1:0]  name_ff, name_in;
   logic [STATE_BITS-1:0] state_ff, state_in;
   logic                  at_idx, above_idx;

   assign at_idx    = (MY_IDX == idx);
   assign above_idx = (MY_IDX > idx);

   // Pick the next content: shift from a neighbor, take the new entry, take a new state, or hold.
   always_comb begin
      name_in  = name_ff;
      state_in = state_ff;
      if (op.ins && above_idx) begin
         name_in  = prev_name;
         state_in = prev_state;
      end else if (op.ins && at_idx) begin
         name_in  = new_name;
         state_in = new_state;
      end else if (op.rem && (above_idx || at_idx)) begin
         name_in  = next_name;
         state_in = next_state;
      end else if (op.set && at_idx) begin
         state_in = new_state;
      end
   end

   // Entry storage; contents are meaningful only below the fill count.
   always_ff @(posedge clock) begin
      name_ff  <= name_in;
      state_ff <= state_in;
   end

   assign name_o  = name_ff;
   assign state_o = state_ff;

endmodule

// ===== src/positional_task_list.sv =====
// Ordered task list held in a chain of DEPTH cells. Position 1 is the front.
// Requests arrive on the req_ channel (req_valid/req_stall) and each one
// produces exactly one transaction on the rsp_ channel (rsp_valid/rsp_stall).
// Kinds: insert at a position (0 or 1 means front), remove at a position,
// set the state of an entry, read an entry. Every cell shifts toward or away
// from its neighbor in the same cycle, so the time an insert or remove takes
// does not depend on the fill level.
// Latency: the result is registered and shows up on the cycle after the
// request is accepted. Throughput: one request per cycle while the receiver
// takes results without stalling, set by the single output register.
// Errors (out of range, full, empty) leave the list unchanged and return
// zero position, name and state with the error status. rsp_entry_count is
// the fill level after the request.
// When the receiver stalls while a result is waiting, req_stall is raised and
// no new request is taken until that result is delivered.
// Reset empties the list and drops any pending result; cell contents are
// not cleared, since only entries below the fill count are ever read.
module positional_task_list #(
   parameter int DEPTH      = 16,
   parameter int NAME_BITS  = 64,
   parameter int STATE_BITS = 3
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_type,
   input  logic [$clog2(DEPTH+2)-1:0]           req_position,
   input  logic [NAME_BITS-1:0]                 req_name_word,
   input  logic [STATE_BITS-1:0]                req_task_state,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic [$clog2(DEPTH+2)-1:0]           rsp_position_out,
   output logic [NAME_BITS-1:0]                 rsp_name_out,
   output logic [STATE_BITS-1:0]                rsp_state_out,
   output logic [$clog2(DEPTH+1)-1:0]           rsp_entry_count
);

   localparam int POS_W = $clog2(DEPTH + 2);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic                    req_accept;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rsp_valid_ff;
   logic [1:0]              status_ff, status_in;
   logic [POS_W-1:0]        pos_out_ff, pos_out_in;
   logic [NAME_BITS-1:0]    name_out_ff, name_out_in;
   logic [STATE_BITS-1:0]   state_out_ff, state_out_in;

   logic [POS_W-1:0]        pos_c, pos_m1, cnt_ext;
   logic [IDX_W-1:0]        idx;
   ptl_pkg::cell_op_type    op;
   logic                    ins_ok;

   logic [NAME_BITS-1:0]    cell_name  [DEPTH];
   logic [STATE_BITS-1:0]   cell_state [DEPTH];
   logic [NAME_BITS-1:0]    rd_name;
   logic [STATE_BITS-1:0]   rd_state;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // Position decode: insert clamps zero to the front.
   assign pos_c   = ((req_type == ptl_pkg::OP_INSERT) && (req_position == '0))
                    ? POS_W'(1) : req_position;
   assign pos_m1  = pos_c - POS_W'(1);
   assign idx     = pos_m1[IDX_W-1:0];
   assign cnt_ext = POS_W'(count_ff);

   // Read port: one-hot select of the cell at the requested index.
   always_comb begin
      rd_name  = '0;
      rd_state = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (IDX_W'(i) == idx) begin
            rd_name  = rd_name  | cell_name[i];
            rd_state = rd_state | cell_state[i];
         end
      end
   end

   // Request decode, checks and result formation.
   always_comb begin
      op           = '0;
      ins_ok       = 1'b0;
      count_in     = count_ff;
      status_in    = ptl_pkg::ST_OK;
      pos_out_in   = '0;
      name_out_in  = '0;
      state_out_in = '0;
      if (req_type == ptl_pkg::OP_INSERT) begin
         if (count_ff == FULL_CNT) begin
            status_in = ptl_pkg::ST_FULL;
         end else if ({1'b0, pos_c} > ({1'b0, cnt_ext} + (POS_W+1)'(1))) begin
            status_in = ptl_pkg::ST_RANGE;
         end else begin
            ins_ok     = 1'b1;
            op.ins     = req_accept;
            count_in   = count_ff + CNT_W'(1);
            pos_out_in = pos_c;
         end
      end else if (count_ff == '0) begin
         status_in = ptl_pkg::ST_EMPTY;
      end else if ((pos_c == '0) || (pos_c > cnt_ext)) begin
         status_in = ptl_pkg::ST_RANGE;
      end else begin
         pos_out_in = pos_c;
         case (req_type)
            ptl_pkg::OP_REMOVE: begin
               op.rem       = req_accept;
               count_in     = count_ff - CNT_W'(1);
               name_out_in  = rd_name;
               state_out_in = rd_state;
            end
            ptl_pkg::OP_SET: begin
               op.set = req_accept;
            end
            default: begin
               name_out_in  = rd_name;
               state_out_in = rd_state;
            end
         endcase
      end
   end

   // The chain of entry cells; each takes from its neighbors on a shift.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      ptl_cell #(
         .INDEX      (g),
         .IDX_W      (IDX_W),
         .NAME_BITS  (NAME_BITS),
         .STATE_BITS (STATE_BITS)
      ) u_cell (
         .clock      (clock),
         .op         (op),
         .idx        (idx),
         .new_name   (req_name_word),
         .new_state  (req_task_state),
         .prev_name  ((g == 0) ? req_name_word : cell_name[(g == 0) ? 0 : g - 1]),
         .prev_state ((g == 0) ? req_task_state : cell_state[(g == 0) ? 0 : g - 1]),
         .next_name  (cell_name[(g == DEPTH - 1) ? g : g + 1]),
         .next_state (cell_state[(g == DEPTH - 1) ? g : g + 1]),
         .name_o     (cell_name[g]),
         .state_o    (cell_state[g])
      );
   end

   // Fill count and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_accept) begin
         status_ff    <= status_in;
         pos_out_ff   <= pos_out_in;
         name_out_ff  <= name_out_in;
         state_out_ff <= state_out_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_position_out = pos_out_ff;
   assign rsp_name_out     = name_out_ff;
   assign rsp_state_out    = state_out_ff;
   assign rsp_entry_count  = count_ff;

`ifndef SYNTHESIS
   // The fill count never passes the list depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("fill count exceeds depth");

   // A successful insert grows the list by exactly one entry.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      req_accept && ins_ok |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the list");

   // A failed request returns no position, name or state.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff != ptl_pkg::ST_OK)
         |-> (pos_out_ff == '0) && (name_out_ff == '0) && (state_out_ff == '0))
      else $error("error result carries data");
`endif

endmodule

// ===== bench/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH      = 16;
   localparam int NAME_BITS  = 64;
   localparam int STATE_BITS = 3;
   localparam int POS_W      = $clog2(DEPTH + 2);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int RANDOM_ITEMS = 600;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic [1:0]            status;
      logic [POS_W-1:0]      position;
      logic [NAME_BITS-1:0]  name;
      logic [STATE_BITS-1:0] state;
      logic [CNT_W-1:0]      fill;
   } list_result_type;

   // Shadow copy of the task list; it works out the result of every accepted
   // request and checks the response transactions against them in order.
   class task_list_shadow_type;
      logic [NAME_BITS-1:0]  names [DEPTH];
      logic [STATE_BITS-1:0] states [DEPTH];
      int                    fill;
      list_result_type       pending_results[$];
      int                    mismatches;

      function new();
         fill = 0;
         mismatches = 0;
      endfunction

      function void apply_request(logic [1:0] op, logic [POS_W-1:0] pos,
                                  logic [NAME_BITS-1:0] name,
                                  logic [STATE_BITS-1:0] st);
         list_result_type r;
         int p;
         int i;
         r = '0;
         r.status = ptl_pkg::ST_OK;
         p = int'(pos);
         if (op == ptl_pkg::OP_INSERT) begin
            // Position zero lands at the front, like position one.
            if (p < 1) p = 1;
            if (fill >= DEPTH) begin
               r.status = ptl_pkg::ST_FULL;
            end else if (p > fill + 1) begin
               r.status = ptl_pkg::ST_RANGE;
            end else begin
               for (i = fill; i >= p; i--) begin
                  names[i] = names[i-1];
                  states[i] = states[i-1];
               end
               names[p-1] = name;
               states[p-1] = st;
               fill++;
               r.position = POS_W'(p);
            end
         end else if (fill == 0) begin
            r.status = ptl_pkg::ST_EMPTY;
         end else if (p < 1 || p > fill) begin
            r.status = ptl_pkg::ST_RANGE;
         end else begin
            r.position = POS_W'(p);
            case (op)
               ptl_pkg::OP_REMOVE: begin
                  r.name = names[p-1];
                  r.state = states[p-1];
                  for (i = p - 1; i + 1 < fill; i++) begin
                     names[i] = names[i+1];
                     states[i] = states[i+1];
                  end
                  fill--;
               end
               ptl_pkg::OP_SET: begin
                  states[p-1] = st;
               end
               default: begin
                  r.name = names[p-1];
                  r.state = states[p-1];
               end
            endcase
         end
         r.fill = CNT_W'(fill);
         pending_results.push_back(r);
      endfunction

      function void compare_field(string field, logic [63:0] expected, logic [63:0] actual);
         if (expected !== actual) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, expected, actual);
         end
      endfunction

      function void check_result(list_result_type actual);
         list_result_type expected;
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: response with no request outstanding, got status %0d position %0d",
                     $time, actual.status, actual.position);
         end else begin
            expected = pending_results.pop_front();
            compare_field("status", 64'(expected.status), 64'(actual.status));
            compare_field("position", 64'(expected.position), 64'(actual.position));
            compare_field("name", 64'(expected.name), 64'(actual.name));
            compare_field("state", 64'(expected.state), 64'(actual.state));
            compare_field("entry count", 64'(expected.fill), 64'(actual.fill));
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_type = ptl_pkg::OP_READ;
   logic [POS_W-1:0]      req_position = '0;
   logic [NAME_BITS-1:0]  req_name_word = '0;
   logic [STATE_BITS-1:0] req_task_state = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_status;
   logic [POS_W-1:0]      rsp_position_out;
   logic [NAME_BITS-1:0]  rsp_name_out;
   logic [STATE_BITS-1:0] rsp_state_out;
   logic [CNT_W-1:0]      rsp_entry_count;

   task_list_shadow_type shadow = new();

   // Sender bookkeeping: fill level the stimulus expects, and burst state.
   int plan_fill = 0;
   int burst_left = 0;

   positional_task_list #(
      .DEPTH(DEPTH),
      .NAME_BITS(NAME_BITS),
      .STATE_BITS(STATE_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_position(req_position),
      .req_name_word(req_name_word),
      .req_task_state(req_task_state),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_position_out(rsp_position_out),
      .rsp_name_out(rsp_name_out),
      .rsp_state_out(rsp_state_out),
      .rsp_entry_count(rsp_entry_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Watch both channels at the rising edge; a response always belongs to an
   // earlier request, so it is checked before the new one is noted.
   always @(posedge clock) begin
      list_result_type seen;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_status, rsp_position_out, rsp_name_out, rsp_state_out,
                    rsp_entry_count};
            shadow.check_result(seen);
         end
         if (req_valid && !req_stall) begin
            shadow.apply_request(req_type, req_position, req_name_word, req_task_state);
         end
      end
   end

   // Give up if the run hangs.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // Receiver: the stall pattern is redrawn for each segment, with two long hold-offs
   // so that the list backs up and stalls the request side.
   initial begin : receiver
      int segment;
      int mode;
      int k;
      segment = 0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (segment == 3 || segment == 11) begin
            rsp_stall <= 1'b1;
            repeat (60) @(negedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            for (k = 0; k < 32; k++) begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  2: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default: rsp_stall <= k[0];
               endcase
               @(negedge clock);
            end
         end
         segment++;
      end
   end

   function automatic logic [NAME_BITS-1:0] pick_name();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Offer one request transaction and hold it until it is taken. Entered and
   // left at a falling edge; a new burst starts after a random gap.
   task automatic send_request(logic [1:0] op, int pos, logic [NAME_BITS-1:0] name,
                               logic [STATE_BITS-1:0] st);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_type <= op;
      req_position <= POS_W'(pos);
      req_name_word <= name;
      req_task_state <= st;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      // Track the fill level so that later positions can be aimed.
      if (op == ptl_pkg::OP_INSERT) begin
         if (plan_fill < DEPTH && pos <= plan_fill + 1) plan_fill++;
      end else if (op == ptl_pkg::OP_REMOVE && pos >= 1 && pos <= plan_fill) begin
         plan_fill--;
      end
   endtask

   initial begin : stimulus
      int n;
      int op_pick;
      int pos;
      logic [1:0] op;
      bit filling;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty list, front inserts, append, range errors.
      send_request(ptl_pkg::OP_READ, 1, '0, '0);
      send_request(ptl_pkg::OP_REMOVE, 0, '0, '0);
      send_request(ptl_pkg::OP_SET, 1, '0, 3'd5);
      send_request(ptl_pkg::OP_INSERT, 0, '1, 3'd7);
      send_request(ptl_pkg::OP_INSERT, 1, '0, 3'd0);
      send_request(ptl_pkg::OP_INSERT, 3, pick_name(), 3'd2);
      send_request(ptl_pkg::OP_INSERT, 5, pick_name(), 3'd4);
      send_request(ptl_pkg::OP_READ, 0, '0, '0);
      send_request(ptl_pkg::OP_READ, 31, '0, '0);
      send_request(ptl_pkg::OP_SET, 2, '0, 3'd6);
      send_request(ptl_pkg::OP_READ, 2, '0, '0);
      // Fill to the top, then poke at the full list and its last entry.
      while (plan_fill < DEPTH) begin
         send_request(ptl_pkg::OP_INSERT, $urandom_range(0, plan_fill + 1), pick_name(),
                      STATE_BITS'($urandom));
      end
      send_request(ptl_pkg::OP_INSERT, 0, pick_name(), 3'd3);
      send_request(ptl_pkg::OP_READ, 16, '0, '0);
      send_request(ptl_pkg::OP_READ, 17, '0, '0);
      send_request(ptl_pkg::OP_SET, 16, '0, 3'd1);
      send_request(ptl_pkg::OP_REMOVE, 16, '0, '0);
      send_request(ptl_pkg::OP_INSERT, 17, pick_name(), 3'd5);
      send_request(ptl_pkg::OP_REMOVE, 1, '0, '0);

      // Random: mostly in-range requests that sweep the list between empty
      // and full, mixed with arbitrary positions and kinds.
      filling = 1'b0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (plan_fill == 0) filling = 1'b1;
         else if (plan_fill == DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
         if ($urandom_range(0, 99) < 12) begin
            op = 2'($urandom_range(0, 3));
            pos = $urandom_range(0, 31);
         end else begin
            op_pick = $urandom_range(0, 99);
            if (op_pick < 15) op = ptl_pkg::OP_READ;
            else if (op_pick < 25) op = ptl_pkg::OP_SET;
            else if (op_pick < 85) op = filling ? ptl_pkg::OP_INSERT : ptl_pkg::OP_REMOVE;
            else op = filling ? ptl_pkg::OP_REMOVE : ptl_pkg::OP_INSERT;
            if (op == ptl_pkg::OP_INSERT) pos = $urandom_range(0, plan_fill + 1);
            else if (plan_fill == 0) pos = 1;
            else pos = $urandom_range(1, plan_fill);
         end
         send_request(op, pos, pick_name(), STATE_BITS'($urandom));
      end
      req_valid <= 1'b0;

      // Drain outstanding responses, then report the verdict.
      while (shadow.pending_results.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (shadow.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== positional_task_list.f =====
src/ptl_pkg.sv
src/ptl_cell.sv
src/positional_task_list.sv
bench/testbench.sv
